>>> src/mmrsa_pkg.sv
// ----------------------------------------------------------------------------
// mmrsa_pkg
// Shared constants for the min/max rejecting sample accumulator.
// ----------------------------------------------------------------------------
package mmrsa_pkg;

  localparam int SAMPLE_W       = 12;
  localparam int SUM_W          = 17;  // 31 * 4095 < 2^17
  localparam int RESULT_W       = 16;

  // Samples after the seed sample; legal range 2..31.
  localparam int FOLLOW_SAMPLES = 17;
  localparam int POS_W          = 5;

  // Scale = 24525 / 30208, with 30208 = 59 * 2^9.
  localparam int SCALE_NUM      = 24525;
  localparam int SCALE_NUM_W    = 15;
  localparam int PROD_W         = SUM_W + SCALE_NUM_W;  // 32
  localparam int DEN_SHIFT      = 9;
  localparam int QIN_W          = PROD_W - DEN_SHIFT;   // 23

  // floor(x / 59) == (x * RECIP) >> RECIP_SHIFT, exact for x < 2^29.
  localparam int RECIP          = 9099507;
  localparam int RECIP_W        = 24;
  localparam int RECIP_SHIFT    = 29;
  localparam int QPROD_W        = QIN_W + RECIP_W;      // 47

endpackage

>>> src/min_max_rejecting_sample_accumulator_unit.sv
// ----------------------------------------------------------------------------
// min_max_rejecting_sample_accumulator_unit
// Trimmed sum over frames of one seed sample plus FOLLOW_SAMPLES samples,
// scaled by 24525/30208 and floored.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+------------------------
//  sample  | in        | sample_valid / sample_stall | sample[11:0]
//  result  | out       | result_valid / result_stall | scaled_sum[15:0]
//
//  Flow: one sample per cycle while sample_stall is low. The compare-and-add
//  updates the running state in the cycle of acceptance; the frame's final
//  sum then runs through three registered stages (sum, sum*24525, divide by
//  59*512) on its way to the result output.
//  Reset: rst is synchronous, active high; it empties the pipe and waits for
//  a seed sample. Stalls: result_stall fills the pipe back to sample_stall;
//  the output register and two inner stages keep samples flowing meanwhile.
//
module min_max_rejecting_sample_accumulator_unit
  import mmrsa_pkg::*;
(
  input  logic                clk,
  input  logic                rst,

  input  logic                sample_valid,
  output logic                sample_stall,
  input  logic [SAMPLE_W-1:0] sample,

  output logic                result_valid,
  input  logic                result_stall,
  output logic [RESULT_W-1:0] scaled_sum
);

  // --------------------------------------------------------------------------
  // Running frame state
  // --------------------------------------------------------------------------
  logic [POS_W-1:0]    pos;
  logic [SAMPLE_W-1:0] run_min;
  logic [SAMPLE_W-1:0] run_max;
  logic [SUM_W-1:0]    psum;

  // Pipeline after the accumulator
  logic                s1_valid;
  logic [SUM_W-1:0]    s1_sum;      // final trimmed sum of a frame
  logic                s2_valid;
  logic [PROD_W-1:0]   s2_prod;     // sum * 24525

  // Elastic ready chain, output side back to input side.
  logic rdy_out, rdy_s2, rdy_s1;
  assign rdy_out      = !result_valid || !result_stall;
  assign rdy_s2       = !s2_valid || rdy_out;
  assign rdy_s1       = !s1_valid || rdy_s2;
  assign sample_stall = !rdy_s1;

  logic take;
  assign take = sample_valid && rdy_s1;

  // --------------------------------------------------------------------------
  // Compare-and-add: the value added is the displaced extreme or the sample.
  // --------------------------------------------------------------------------
  logic                seed;
  logic                last;
  logic                below_min, above_max;
  logic [SAMPLE_W-1:0] add_val;
  logic [SUM_W-1:0]    psum_next;

  assign seed      = (pos == '0);
  // A position past the end is treated as the last sample.
  assign last      = (pos >= POS_W'(FOLLOW_SAMPLES));
  assign below_min = (sample < run_min);
  assign above_max = (sample > run_max);

  always_comb begin
    if (below_min) begin
      add_val = run_min;
    end else if (above_max) begin
      add_val = run_max;
    end else begin
      add_val = sample;
    end
  end

  assign psum_next = psum + SUM_W'(add_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      run_min <= '0;
      run_max <= '0;
      psum    <= '0;
    end else if (take) begin
      if (seed) begin
        run_min <= sample;
        run_max <= '0;
        psum    <= '0;
        pos     <= POS_W'(1);
      end else begin
        if (below_min) begin
          run_min <= sample;
        end else if (above_max) begin
          run_max <= sample;
        end
        psum <= psum_next;
        if (last) begin
          pos <= '0;
        end else begin
          pos <= pos + POS_W'(1);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: capture the frame's final sum.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rdy_s1) begin
      s1_valid <= take && !seed && last;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_s1 && take && !seed && last) begin
      s1_sum <= psum_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: multiply by the numerator (fits in 32 bits).
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (rdy_s2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_s2 && s1_valid) begin
      s2_prod <= PROD_W'(s1_sum) * PROD_W'(SCALE_NUM);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: divide by 512 (shift), then by 59 via exact reciprocal.
  // Wraps to the low 16 bits.
  // --------------------------------------------------------------------------
  logic [QIN_W-1:0]   q_in;
  logic [QPROD_W-1:0] q_prod;

  assign q_in   = s2_prod[PROD_W-1:DEN_SHIFT];
  assign q_prod = QPROD_W'(q_in) * QPROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (rdy_out) begin
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out && s2_valid) begin
      scaled_sum <= q_prod[RECIP_SHIFT +: RESULT_W];
    end
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the min/max rejecting sample accumulator. A short
// table of directed frames runs first, then random frames with mixed value
// shapes. Both handshakes idle in random bursts. A bit-exact local model
// predicts every scaled sum not typed in the directed table, and the bench
// compares them in order with what the block returns.
// ----------------------------------------------------------------------------
module tb;
  import mmrsa_pkg::*;

  localparam int SCALE_DEN     = 30208;
  localparam int PREDICT       = -1;   // table row checked by the model only
  localparam int DIR_N         = 36;
  localparam int RAND_FRAMES   = 23;
  localparam int CALM_FRAMES   = 6;    // trailing frames with no idling
  localparam int HOLD_FRAME    = 10;   // long receiver hold-off starts here
  localparam int DRAIN_FRAME   = 20;   // sender waits for an empty pipe here
  localparam int LONG_HOLD     = 200;
  localparam int END_DRAIN     = 20;
  localparam int RUN_LIMIT_NS  = 200000;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                sample_valid = 1'b0;
  logic                sample_stall;
  logic [SAMPLE_W-1:0] sample       = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic [RESULT_W-1:0] scaled_sum;

  min_max_rejecting_sample_accumulator_unit uut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .scaled_sum   (scaled_sum)
  );

  always #1 clk = ~clk;

  // Directed frames. First: seed at max, then the minimum branch, the
  // maximum branch, ties with both bounds and alternating bit patterns.
  // Second: every sample at full scale, sum 16 * 4095.
  int dir_sample [DIR_N] = '{
    4095, 0, 4095, 2048, 4095, 0, 1, 4094, 2730, 1365, 2047, 2049, 3, 4092,
    0, 4095, 1000, 3000,
    4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095,
    4095, 4095, 4095, 4095, 4095, 4095
  };
  int dir_sum [DIR_N] = '{
    PREDICT, PREDICT, PREDICT, PREDICT, PREDICT, PREDICT, PREDICT, PREDICT,
    PREDICT, PREDICT, PREDICT, PREDICT, PREDICT, PREDICT, PREDICT, PREDICT,
    PREDICT, PREDICT,
    PREDICT, PREDICT, PREDICT, PREDICT, PREDICT, PREDICT, PREDICT, PREDICT,
    PREDICT, PREDICT, PREDICT, PREDICT, PREDICT, PREDICT, PREDICT, PREDICT,
    PREDICT, 53193
  };

  // Trim model state
  logic [POS_W-1:0]    frame_pos;
  logic [SAMPLE_W-1:0] low_mark;
  logic [SAMPLE_W-1:0] high_mark;
  logic [SUM_W-1:0]    trim_sum;

  logic [RESULT_W-1:0] expected_sums [$];
  int                  err_count  = 0;
  bit                  calm       = 1'b0;
  int                  hold_reqs  = 0;
  int                  holds_done = 0;
  int                  hold_left  = 0;
  int                  rx_burst   = 0;

  // Advance the trim model by one sample; returns 1 when a frame closes.
  function automatic bit trim_step(input logic [SAMPLE_W-1:0] s,
                                   output logic [RESULT_W-1:0] q);
    logic [63:0] prod;
    q = '0;
    if (frame_pos == '0) begin
      low_mark  = s;
      high_mark = '0;
      trim_sum  = '0;
      frame_pos = POS_W'(1);
      return 1'b0;
    end
    if (s < low_mark) begin
      trim_sum = trim_sum + SUM_W'(low_mark);
      low_mark = s;
    end else if (s > high_mark) begin
      trim_sum  = trim_sum + SUM_W'(high_mark);
      high_mark = s;
    end else begin
      trim_sum = trim_sum + SUM_W'(s);
    end
    if (frame_pos >= POS_W'(FOLLOW_SAMPLES)) begin
      prod      = 64'(trim_sum) * 64'(SCALE_NUM) / 64'(SCALE_DEN);
      q         = prod[RESULT_W-1:0];
      frame_pos = '0;
      return 1'b1;
    end
    frame_pos = frame_pos + 1'b1;
    return 1'b0;
  endfunction

  // Present one request, hold it until accepted, then maybe idle.
  task automatic offer_sample(input logic [SAMPLE_W-1:0] s, input int typed_sum);
    logic [RESULT_W-1:0] q;
    bit                  fires;
    sample_valid <= 1'b1;
    sample       <= s;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    fires = trim_step(s, q);
    if (fires) expected_sums.push_back(typed_sum >= 0 ? typed_sum[RESULT_W-1:0] : q);
    if (!calm && $urandom_range(0, 5) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Result side: check accepted results, drive stall
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_sums.size() == 0) begin
        $error("scaled_sum: expected none, got %0d", scaled_sum);
        err_count++;
      end else begin
        if (scaled_sum !== expected_sums[0]) begin
          $error("scaled_sum: expected %0d, got %0d", expected_sums[0], scaled_sum);
          err_count++;
        end
        void'(expected_sums.pop_front());
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (hold_reqs != holds_done) begin
      holds_done++;
      hold_left = LONG_HOLD - 1;
      result_stall <= 1'b1;
    end else if (calm) begin
      result_stall <= 1'b0;
    end else if (rx_burst > 0) begin
      rx_burst--;
      result_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      rx_burst = $urandom_range(1, 15) - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  initial begin
    int                  mode;
    int                  center;
    int                  step;
    int                  v;
    logic [SAMPLE_W-1:0] s;
    frame_pos = '0;
    low_mark  = '0;
    high_mark = '0;
    trim_sum  = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_N; i++) offer_sample(SAMPLE_W'(dir_sample[i]), dir_sum[i]);

    for (int f = 0; f < RAND_FRAMES; f++) begin
      if (f == HOLD_FRAME) hold_reqs++;
      if (f == DRAIN_FRAME) begin
        sample_valid <= 1'b0;
        @(posedge clk);
        while (expected_sums.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      if (f == RAND_FRAMES - CALM_FRAMES) calm = 1'b1;
      mode   = $urandom_range(0, 4);
      center = $urandom_range(0, 4095);
      step   = $urandom_range(1, 240);
      for (int k = 0; k <= FOLLOW_SAMPLES; k++) begin
        case (mode)
          0: v = $urandom_range(0, 4095);
          1: begin
            case ($urandom_range(0, 3))
              0: v = 0;
              1: v = 4095;
              2: v = 1;
              default: v = 4094;
            endcase
          end
          2: v = center + $urandom_range(0, 16) - 8;
          3: v = center + k * step;
          default: v = center - k * step;
        endcase
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        s = SAMPLE_W'(v);
        offer_sample(s, PREDICT);
      end
    end
    sample_valid <= 1'b0;

    while (expected_sums.size() != 0) @(posedge clk);
    repeat (END_DRAIN) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("tb: errors");
    $finish;
  end

endmodule
